// ===== hdl/caob_pkg.sv =====
// ----------------------------------------------------------------------------
// caob_pkg
// Shared types and constants of the clipped alpha-over blit unit.
// ----------------------------------------------------------------------------
package caob_pkg;

	// configuration field widths
	localparam int CANVAS_DIM_W = 9;
	localparam int ORIGIN_W     = 13;
	localparam int TILE_DIM_W   = 13;

	// wide enough for any canvas index the block can form or be asked for
	localparam int IDX_W = 21;

	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	localparam int PIXEL_W = 32;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_PIXEL = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		REG_CANVAS_WIDTH  = 3'd0,
		REG_CANVAS_HEIGHT = 3'd1,
		REG_DEST_X        = 3'd2,
		REG_DEST_Y        = 3'd3,
		REG_TILE_WIDTH    = 3'd4,
		REG_TILE_HEIGHT   = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic        [CANVAS_DIM_W-1:0] canvas_width;
		logic        [CANVAS_DIM_W-1:0] canvas_height;
		logic signed [ORIGIN_W-1:0]     dest_x;
		logic signed [ORIGIN_W-1:0]     dest_y;
		logic        [TILE_DIM_W-1:0]   tile_width;
		logic        [TILE_DIM_W-1:0]   tile_height;
	} cfg_t;

	localparam logic [CANVAS_DIM_W-1:0] CANVAS_DIM_RST = 9'd256;
	localparam logic [TILE_DIM_W-1:0]   TILE_DIM_RST   = 13'd256;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pixel_t;

	typedef struct packed {
		logic               we;
		logic               re;
		logic [IDX_W-1:0]   addr;
		logic [PIXEL_W-1:0] wdata;
	} mem_req_t;

	typedef struct packed {
		logic               valid;
		logic [PIXEL_W-1:0] rgba;
	} blend_res_t;

endpackage

// ===== hdl/caob_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// caob_cfg_regs
// APB register bank holding canvas size, tile origin and tile size.
// ----------------------------------------------------------------------------
module caob_cfg_regs (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [caob_pkg::APB_AW-1:0] paddr,
	input  logic [caob_pkg::APB_DW-1:0] pwdata,
	output logic [caob_pkg::APB_DW-1:0] prdata,
	output logic                     pready,
	output caob_pkg::cfg_t           cfg
);
	import caob_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:2]);
	assign wr_en   = psel & penable & pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.canvas_width  <= CANVAS_DIM_RST;
			cfg_q.canvas_height <= CANVAS_DIM_RST;
			cfg_q.dest_x        <= '0;
			cfg_q.dest_y        <= '0;
			cfg_q.tile_width    <= TILE_DIM_RST;
			cfg_q.tile_height   <= TILE_DIM_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_CANVAS_WIDTH:  cfg_q.canvas_width  <= pwdata[CANVAS_DIM_W-1:0];
				REG_CANVAS_HEIGHT: cfg_q.canvas_height <= pwdata[CANVAS_DIM_W-1:0];
				REG_DEST_X:        cfg_q.dest_x        <= signed'(pwdata[ORIGIN_W-1:0]);
				REG_DEST_Y:        cfg_q.dest_y        <= signed'(pwdata[ORIGIN_W-1:0]);
				REG_TILE_WIDTH:    cfg_q.tile_width    <= pwdata[TILE_DIM_W-1:0];
				REG_TILE_HEIGHT:   cfg_q.tile_height   <= pwdata[TILE_DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_CANVAS_WIDTH:  prdata = APB_DW'(cfg_q.canvas_width);
			REG_CANVAS_HEIGHT: prdata = APB_DW'(cfg_q.canvas_height);
			REG_DEST_X:        prdata = APB_DW'(unsigned'(cfg_q.dest_x));
			REG_DEST_Y:        prdata = APB_DW'(unsigned'(cfg_q.dest_y));
			REG_TILE_WIDTH:    prdata = APB_DW'(cfg_q.tile_width);
			REG_TILE_HEIGHT:   prdata = APB_DW'(cfg_q.tile_height);
			default:           prdata = '0;
		endcase
	end

endmodule

// ===== hdl/caob_canvas_ram.sv =====
// ----------------------------------------------------------------------------
// caob_canvas_ram
// Single-port canvas store, one access a cycle, registered read data.
// ----------------------------------------------------------------------------
module caob_canvas_ram #(
	parameter int DEPTH = 65536
) (
	input  logic                      clk,
	input  caob_pkg::mem_req_t        req,
	output logic [caob_pkg::PIXEL_W-1:0] rdata
);
	import caob_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic [PIXEL_W-1:0] mem [DEPTH];
	logic [AW-1:0]      addr;

	assign addr = req.addr[AW-1:0];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[addr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== hdl/caob_blend.sv =====
// ----------------------------------------------------------------------------
// caob_blend
// Two-stage source-over blend: products in the first stage, the exact
// divide by 255 and the alpha sum in the second.
// ----------------------------------------------------------------------------
module caob_blend (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  caob_pkg::pixel_t             src,
	input  logic [caob_pkg::PIXEL_W-1:0] dst,
	output caob_pkg::blend_res_t         res
);
	import caob_pkg::*;

	// exact floor(x/255) for x below 65280
	function automatic logic [7:0] div255(input logic [16:0] x);
		logic [16:0] t;
		t = x + 17'd1 + 17'(x[16:8]);
		return t[15:8];
	endfunction

	pixel_t     d;
	logic [7:0] inv_a;

	logic        vld_s1;
	logic [15:0] sr_s1, sg_s1, sb_s1;
	logic [15:0] dr_s1, dg_s1, db_s1, da_s1;
	logic [7:0]  a_s1;

	logic [7:0]  nr, ng, nb, na;
	logic [8:0]  a_sum;

	logic               vld_s2;
	logic [PIXEL_W-1:0] rgba_s2;

	assign d     = pixel_t'(dst);
	assign inv_a = 8'd255 - src.alpha;

	always_ff @(posedge clk) begin
		sr_s1 <= 16'(src.red)   * 16'(src.alpha);
		sg_s1 <= 16'(src.green) * 16'(src.alpha);
		sb_s1 <= 16'(src.blue)  * 16'(src.alpha);
		dr_s1 <= 16'(d.red)     * 16'(inv_a);
		dg_s1 <= 16'(d.green)   * 16'(inv_a);
		db_s1 <= 16'(d.blue)    * 16'(inv_a);
		da_s1 <= 16'(d.alpha)   * 16'(inv_a);
		a_s1  <= src.alpha;
	end

	always_comb begin
		nr    = div255(17'(sr_s1) + 17'(dr_s1));
		ng    = div255(17'(sg_s1) + 17'(dg_s1));
		nb    = div255(17'(sb_s1) + 17'(db_s1));
		a_sum = 9'(a_s1) + 9'(div255(17'(da_s1)));
		na    = a_sum[8] ? 8'd255 : a_sum[7:0];
	end

	always_ff @(posedge clk) begin
		rgba_s2 <= {nr, ng, nb, na};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	assign res.valid = vld_s2;
	assign res.rgba  = rgba_s2;

endmodule

// ===== hdl/caob_seq.sv =====
// ----------------------------------------------------------------------------
// caob_seq
// Op sequencer: tile counters, canvas position and clipping, read-modify-
// write of the canvas store, clearing sweep and the result register.
// ----------------------------------------------------------------------------
module caob_seq #(
	parameter int MAX_CANVAS_PIXELS = 65536,
	parameter int MAX_TILE_DIM      = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  caob_pkg::cfg_t               cfg,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   in_op,
	input  caob_pkg::pixel_t             in_pixel,
	input  logic [15:0]                  in_read_index,
	output caob_pkg::mem_req_t           mem_req,
	input  logic [caob_pkg::PIXEL_W-1:0] mem_rdata,
	output logic                         blend_start,
	output caob_pkg::pixel_t             blend_src,
	input  caob_pkg::blend_res_t         blend_res,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [caob_pkg::PIXEL_W-1:0] out_data
);
	import caob_pkg::*;

	localparam int AW = $clog2(MAX_CANVAS_PIXELS);
	localparam int CW = $clog2(MAX_TILE_DIM);
	localparam int DW = (CW + 1 > TILE_DIM_W) ? CW + 1 : TILE_DIM_W;
	localparam int PW = DW + 1;
	localparam logic [IDX_W-1:0] MAX_IDX  = IDX_W'(MAX_CANVAS_PIXELS);
	localparam logic [AW-1:0]    LAST_ADR = AW'(MAX_CANVAS_PIXELS - 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_PIX_POS,
		S_PIX_RD,
		S_PIX_BLEND,
		S_RD_OUT
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      col_q, row_q;
	logic [AW-1:0]      clr_adr_q;
	logic [IDX_W-1:0]   idx_q;
	pixel_t             src_q;
	logic               rd_zero_q;
	logic               out_valid_q;
	logic [PIXEL_W-1:0] out_data_q;

	logic               accept;
	op_t                op;
	logic [IDX_W-1:0]   rd_idx;
	logic [DW-1:0]      tw_dim, th_dim, col_inc, row_inc;
	logic signed [PW-1:0] cx, cy;
	logic               hit_x, hit_y, hit;
	logic [17:0]        row_base;
	logic [IDX_W-1:0]   pos_idx;
	logic               out_free;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid & in_ready;
	assign op       = op_t'(in_op);
	assign rd_idx   = IDX_W'(in_read_index);
	assign out_free = !out_valid_q || out_ready;

	// tile size, zero acting as one and large values capped
	always_comb begin
		if (cfg.tile_width == '0) begin
			tw_dim = DW'(1);
		end else if (DW'(cfg.tile_width) > DW'(MAX_TILE_DIM)) begin
			tw_dim = DW'(MAX_TILE_DIM);
		end else begin
			tw_dim = DW'(cfg.tile_width);
		end
		if (cfg.tile_height == '0) begin
			th_dim = DW'(1);
		end else if (DW'(cfg.tile_height) > DW'(MAX_TILE_DIM)) begin
			th_dim = DW'(MAX_TILE_DIM);
		end else begin
			th_dim = DW'(cfg.tile_height);
		end
		col_inc = DW'(col_q) + DW'(1);
		row_inc = DW'(row_q) + DW'(1);
	end

	// canvas position of the current tile pixel and clipping
	always_comb begin
		cx       = PW'(cfg.dest_x) + signed'(PW'(col_q));
		cy       = PW'(cfg.dest_y) + signed'(PW'(row_q));
		hit_x    = !cx[PW-1] && (cx[PW-2:0] < (PW-1)'(cfg.canvas_width));
		hit_y    = !cy[PW-1] && (cy[PW-2:0] < (PW-1)'(cfg.canvas_height));
		row_base = 18'(cy[CANVAS_DIM_W-1:0]) * 18'(cfg.canvas_width);
		pos_idx  = IDX_W'(row_base) + IDX_W'(cx[CANVAS_DIM_W-1:0]);
		hit      = hit_x && hit_y && (pos_idx < MAX_IDX);
	end

	always_comb begin
		mem_req = '0;
		case (state_q)
			S_CLEAR: begin
				mem_req.we   = 1'b1;
				mem_req.addr = IDX_W'(clr_adr_q);
			end
			S_IDLE: begin
				if (accept && op == OP_READ && rd_idx < MAX_IDX) begin
					mem_req.re   = 1'b1;
					mem_req.addr = rd_idx;
				end
			end
			S_PIX_POS: begin
				mem_req.re   = hit;
				mem_req.addr = pos_idx;
			end
			S_PIX_BLEND: begin
				mem_req.we    = blend_res.valid;
				mem_req.addr  = idx_q;
				mem_req.wdata = blend_res.rgba;
			end
			default: ;
		endcase
	end

	assign blend_start = (state_q == S_PIX_RD);
	assign blend_src   = src_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			src_q     <= in_pixel;
			rd_zero_q <= !(rd_idx < MAX_IDX);
		end
		if (state_q == S_PIX_POS) begin
			idx_q <= pos_idx;
		end
		if (state_q == S_RD_OUT && out_free) begin
			out_data_q <= rd_zero_q ? '0 : mem_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_adr_q   <= '0;
			col_q       <= '0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_RD_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_adr_q <= clr_adr_q + AW'(1);
					if (clr_adr_q == LAST_ADR) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (op)
							OP_CLEAR: begin
								clr_adr_q <= '0;
								col_q     <= '0;
								row_q     <= '0;
								state_q   <= S_CLEAR;
							end
							OP_PIXEL: state_q <= S_PIX_POS;
							OP_READ:  state_q <= S_RD_OUT;
							default:  state_q <= S_IDLE;
						endcase
					end
				end
				S_PIX_POS: begin
					if (col_inc >= tw_dim) begin
						col_q <= '0;
						row_q <= (row_inc >= th_dim) ? '0 : row_inc[CW-1:0];
					end else begin
						col_q <= col_inc[CW-1:0];
					end
					state_q <= hit ? S_PIX_RD : S_IDLE;
				end
				S_PIX_RD: begin
					state_q <= S_PIX_BLEND;
				end
				S_PIX_BLEND: begin
					if (blend_res.valid) begin
						state_q <= S_IDLE;
					end
				end
				S_RD_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTHESIS
	a_no_write_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !mem_req.we)
		else $error("canvas written while accepting a new transaction");

	a_read_data_used: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.re |=> (state_q == S_RD_OUT || state_q == S_PIX_RD))
		else $error("canvas read issued with no consumer of its data");

	a_col_in_tile: assert property (@(posedge clk) disable iff (!arst_n)
		(DW'(col_q) < DW'(MAX_TILE_DIM)) && (DW'(row_q) < DW'(MAX_TILE_DIM)))
		else $error("tile counter beyond the largest tile");

	a_blend_done_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PIX_RD) |=> ##1 (blend_res.valid && mem_req.we))
		else $error("blend result not written back");
`endif

endmodule

// ===== hdl/clipped_alpha_over_blit_unit.sv =====
// ----------------------------------------------------------------------------
// clipped_alpha_over_blit_unit
// Source-over blit of a streamed RGBA tile into a clipped canvas store.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one op per transaction: tuser holds the op (clear, source
//   pixel, read), tdata the source pixel and the read index. Source pixels
//   come in raster order; the tile counters plus the signed origin place each
//   one on the canvas, and pixels off the canvas are dropped.
//   m_axis returns one RRGGBBAA word for each read op, nothing for others.
//   Steps per transaction, in order:
//     source pixel: position, read, two blend stages, write back;
//                   a clipped pixel stops after the position step
//     read:         canvas read, then the output register, held while it is full
//     clear:        the sweep writes every word of the store, one word
//                   a cycle
//   A read is held back only while its result cannot enter the output
//   register; the register takes a new word in the cycle m_axis_tready
//   empties it. After reset the same clearing sweep runs with s_axis_tready
//   low; the APB port accepts writes throughout.
// ----------------------------------------------------------------------------
module clipped_alpha_over_blit_unit #(
	parameter int MAX_CANVAS_PIXELS = 65536,
	parameter int MAX_TILE_DIM      = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [caob_pkg::APB_AW-1:0] paddr,
	input  logic [caob_pkg::APB_DW-1:0] pwdata,
	output logic [caob_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// src_red, src_green, src_blue, src_alpha, read_index
	input  logic [47:0]                 s_axis_tdata,
	// op
	input  logic [1:0]                  s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// pixel_rgba
	output logic [31:0]                 m_axis_tdata
);
	import caob_pkg::*;

	cfg_t               cfg;
	pixel_t             in_pixel;
	mem_req_t           mem_req;
	logic [PIXEL_W-1:0] mem_rdata;
	logic               blend_start;
	pixel_t             blend_src;
	blend_res_t         blend_res;

	assign in_pixel.red   = s_axis_tdata[7:0];
	assign in_pixel.green = s_axis_tdata[15:8];
	assign in_pixel.blue  = s_axis_tdata[23:16];
	assign in_pixel.alpha = s_axis_tdata[31:24];

	caob_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	caob_canvas_ram #(
		.DEPTH (MAX_CANVAS_PIXELS)
	) u_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	caob_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (blend_start),
		.src    (blend_src),
		.dst    (mem_rdata),
		.res    (blend_res)
	);

	caob_seq #(
		.MAX_CANVAS_PIXELS (MAX_CANVAS_PIXELS),
		.MAX_TILE_DIM      (MAX_TILE_DIM)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.in_op         (s_axis_tuser),
		.in_pixel      (in_pixel),
		.in_read_index (s_axis_tdata[47:32]),
		.mem_req       (mem_req),
		.mem_rdata     (mem_rdata),
		.blend_start   (blend_start),
		.blend_src     (blend_src),
		.blend_res     (blend_res),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_data      (m_axis_tdata)
	);

endmodule

// ===== sim/caob_checker.sv =====
// ----------------------------------------------------------------------------
// caob_checker
// Watches the register port and both streams of the blit unit, keeps its
// own canvas, tile counters and register copy, and compares every returned
// canvas word with the word it predicts.
// ----------------------------------------------------------------------------
module caob_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic                          pready,
	input  logic [caob_pkg::APB_AW-1:0]   paddr,
	input  logic [caob_pkg::APB_DW-1:0]   pwdata,
	input  logic                          s_axis_tvalid,
	input  logic                          s_axis_tready,
	input  logic [47:0]                   s_axis_tdata,
	input  logic [1:0]                    s_axis_tuser,
	input  logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	input  logic [31:0]                   m_axis_tdata,
	output int                            fail_count,
	output int                            outstanding
);
	import caob_pkg::*;

	localparam int STORE_DEPTH  = 65536;
	localparam int TILE_DIM_MAX = 4096;
	localparam int REPORT_MAX   = 10;

	logic [PIXEL_W-1:0] canvas_mem [STORE_DEPTH];
	logic [PIXEL_W-1:0] readback_q [$];
	int unsigned        col_pos;
	int unsigned        row_pos;
	cfg_t               cfg;
	int                 errs;
	int                 words_seen;

	function automatic int unsigned eff_dim(logic [TILE_DIM_W-1:0] v);
		if (v == '0)
			return 1;
		if (v > TILE_DIM_MAX)
			return TILE_DIM_MAX;
		return v;
	endfunction

	function automatic logic [7:0] mix_channel(int unsigned s, int unsigned d, int unsigned a);
		return 8'((s * a + d * (255 - a)) / 255);
	endfunction

	task automatic wipe_canvas();
		foreach (canvas_mem[i])
			canvas_mem[i] = '0;
		col_pos = 0;
		row_pos = 0;
	endtask

	task automatic composite(pixel_t src);
		int          cx;
		int          cy;
		int          pos;
		int unsigned sa;
		int unsigned da;
		int unsigned na;
		pixel_t      dst;
		pixel_t      res;
		cx = int'(cfg.dest_x) + int'(col_pos);
		cy = int'(cfg.dest_y) + int'(row_pos);
		if (cx >= 0 && cy >= 0 && cx < int'(cfg.canvas_width) &&
				cy < int'(cfg.canvas_height)) begin
			pos = cy * int'(cfg.canvas_width) + cx;
			// positions whose index runs past the store are dropped
			if (pos < STORE_DEPTH) begin
				dst       = canvas_mem[pos];
				sa        = src.alpha;
				da        = dst.alpha;
				res.red   = mix_channel(src.red, dst.red, sa);
				res.green = mix_channel(src.green, dst.green, sa);
				res.blue  = mix_channel(src.blue, dst.blue, sa);
				na        = sa + (da * (255 - sa)) / 255;
				res.alpha = (na > 255) ? 8'd255 : na[7:0];
				canvas_mem[pos] = res;
			end
		end
		if (col_pos + 1 >= eff_dim(cfg.tile_width)) begin
			col_pos = 0;
			if (row_pos + 1 >= eff_dim(cfg.tile_height))
				row_pos = 0;
			else
				row_pos++;
		end else begin
			col_pos++;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			wipe_canvas();
			readback_q.delete();
			cfg.canvas_width  = CANVAS_DIM_RST;
			cfg.canvas_height = CANVAS_DIM_RST;
			cfg.dest_x        = '0;
			cfg.dest_y        = '0;
			cfg.tile_width    = TILE_DIM_RST;
			cfg.tile_height   = TILE_DIM_RST;
			errs              = 0;
			words_seen        = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[APB_AW-1:2]))
					REG_CANVAS_WIDTH:  cfg.canvas_width  = pwdata[CANVAS_DIM_W-1:0];
					REG_CANVAS_HEIGHT: cfg.canvas_height = pwdata[CANVAS_DIM_W-1:0];
					REG_DEST_X:        cfg.dest_x        = pwdata[ORIGIN_W-1:0];
					REG_DEST_Y:        cfg.dest_y        = pwdata[ORIGIN_W-1:0];
					REG_TILE_WIDTH:    cfg.tile_width    = pwdata[TILE_DIM_W-1:0];
					REG_TILE_HEIGHT:   cfg.tile_height   = pwdata[TILE_DIM_W-1:0];
					default: ;
				endcase
			end
			// tdata: red, green, blue, alpha, then the read index from bit 32
			if (s_axis_tvalid && s_axis_tready) begin
				case (s_axis_tuser)
					OP_CLEAR: wipe_canvas();
					OP_PIXEL: composite({s_axis_tdata[7:0], s_axis_tdata[15:8],
						s_axis_tdata[23:16], s_axis_tdata[31:24]});
					OP_READ:  readback_q.push_back(canvas_mem[s_axis_tdata[47:32]]);
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				words_seen++;
				if (readback_q.size() == 0) begin
					errs++;
					if (errs <= REPORT_MAX)
						$display("result %0d: pixel_rgba %08h with no read waiting",
							words_seen, m_axis_tdata);
				end else if (readback_q[0] !== m_axis_tdata) begin
					errs++;
					if (errs <= REPORT_MAX)
						$display("result %0d: pixel_rgba expected %08h, got %08h",
							words_seen, readback_q[0], m_axis_tdata);
					void'(readback_q.pop_front());
				end else begin
					void'(readback_q.pop_front());
				end
			end
		end
		fail_count  <= errs;
		outstanding <= readback_q.size();
	end

endmodule

// ===== sim/tb_clipped_alpha_over_blit_unit.sv =====
// ----------------------------------------------------------------------------
// tb_clipped_alpha_over_blit_unit
// Drives the blit unit through a short directed sequence and a series of
// canvas and tile settings with random pixels, reads and idle gaps on both
// streams; the checker beside the block judges every returned word.
// ----------------------------------------------------------------------------
module tb_clipped_alpha_over_blit_unit;
	import caob_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int PHASES       = 14;
	localparam int PHASE_ITEMS  = 98;
	localparam int IDLE_MAX     = 18;
	localparam int SETTLE       = 8;

	typedef struct packed {
		logic [15:0] read_index;
		logic [7:0]  src_alpha;
		logic [7:0]  src_blue;
		logic [7:0]  src_green;
		logic [7:0]  src_red;
	} item_data_t;

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [APB_AW-1:0] paddr   = '0;
	logic [APB_DW-1:0] pwdata  = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              s_valid = 1'b0;
	logic              s_axis_tready;
	item_data_t        s_data  = '0;
	logic [1:0]        s_user  = '0;
	logic              m_axis_tvalid;
	logic              m_ready = 1'b0;
	logic [31:0]       m_axis_tdata;

	int fail_count;
	int outstanding;
	int stall;
	int draw;
	int cur_cw;
	int cur_ch;
	bit tx_calm;
	bit rx_calm;

	always #4 clk = ~clk;

	clipped_alpha_over_blit_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_data),
		.s_axis_tuser  (s_user),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_axis_tdata)
	);

	caob_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_data),
		.s_axis_tuser  (s_user),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.outstanding   (outstanding)
	);

	// result side: after each transaction hold tready low for a drawn stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_ready <= 1'b0;
			stall   <= 0;
		end else if (m_axis_tvalid && m_ready) begin
			draw = rx_calm ? 0 : $urandom_range(0, IDLE_MAX);
			stall   <= draw;
			m_ready <= (draw == 0);
		end else if (stall > 1) begin
			stall <= stall - 1;
		end else begin
			stall   <= 0;
			m_ready <= 1'b1;
		end
	end

	task automatic write_reg(reg_idx_t r, logic [APB_DW-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_canvas(int cw, int ch, int dx, int dy, int tw, int th);
		write_reg(REG_CANVAS_WIDTH, 32'(cw));
		write_reg(REG_CANVAS_HEIGHT, 32'(ch));
		write_reg(REG_DEST_X, 32'(dx) & 32'h1FFF);
		write_reg(REG_DEST_Y, 32'(dy) & 32'h1FFF);
		write_reg(REG_TILE_WIDTH, 32'(tw));
		write_reg(REG_TILE_HEIGHT, 32'(th));
		cur_cw = cw;
		cur_ch = ch;
	endtask

	task automatic send_item(logic [1:0] op, item_data_t d);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, IDLE_MAX);
		if (gap > 0) begin
			s_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_valid <= 1'b1;
		s_user  <= op;
		s_data  <= d;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
		item_data_t d;
		d = {16'($urandom), a, b, g, r};
		send_item(OP_PIXEL, d);
	endtask

	task automatic send_read(logic [15:0] idx);
		item_data_t d;
		d = {idx, 32'($urandom)};
		send_item(OP_READ, d);
	endtask

	// lower tvalid, wait for every read to come back, then let the block settle
	task automatic drain();
		s_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_index();
		int area;
		area = cur_cw * cur_ch;
		if (area == 0 || $urandom_range(0, 9) == 0)
			return 16'($urandom_range(0, 65535));
		return 16'($urandom_range(0, area - 1));
	endfunction

	function automatic logic [7:0] pick_alpha();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic run_phase(int p);
		int pick;
		case (p)
			0:  set_canvas(8, 6, -2, -1, 5, 4);
			1:  set_canvas(1, 1, 0, 0, 1, 1);
			2:  set_canvas(16, 16, 3, 2, 7, 5);
			3:  set_canvas(0, 10, 4095, -4096, 4, 4);
			4:  set_canvas(256, 256, 250, 252, 10, 8);
			5:  set_canvas(511, 200, 500, 127, 20, 3);
			6:  set_canvas(12, 9, -4096, 4095, 0, 0);
			7:  set_canvas(10, 10, 0, 0, 8191, 8191);
			8:  set_canvas(20, 12, -3, 2, 0, 6);
			9:  set_canvas(256, 256, 0, 0, 256, 256);
			10: set_canvas(6, 5, 1, 1, 3, 4096);
			11: set_canvas(9, 7, -1, -1, 11, 3);
			12: set_canvas(511, 511, 0, 128, 200, 2);
			default: set_canvas(32, 1, -5, 0, 4097, 1);
		endcase
		tx_calm = (p % 4 == 3);
		rx_calm = (p % 4 == 3);
		// a clear costs a full sweep of the store, so only some phases start with one
		if (p % 4 == 0)
			send_item(OP_CLEAR, 48'($urandom) << 16 | 48'($urandom));
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 64)
				send_pixel(8'($urandom), 8'($urandom), 8'($urandom), pick_alpha());
			else if (pick < 94)
				send_read(pick_index());
			else
				send_item(OP_UNUSED, {16'($urandom), 32'($urandom)});
		end
		send_read(pick_index());
		drain();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// tile of 3x2 at (-1,1) on a 4x3 canvas: first column of each row falls off
		set_canvas(4, 3, -1, 1, 3, 2);
		send_read(16'd0);
		send_read(16'hFFFF);
		send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd128, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd0, 8'd255);
		send_pixel(8'd200, 8'd100, 8'd50, 8'd128);
		// tile wrapped: back to the top left corner over existing pixels
		send_pixel(8'd9, 8'd9, 8'd9, 8'd9);
		send_pixel(8'd10, 8'd20, 8'd30, 8'd77);
		send_item(OP_UNUSED, '1);
		send_read(16'd4);
		send_read(16'd5);
		send_read(16'd8);
		send_read(16'd9);
		send_pixel(8'd255, 8'd255, 8'd255, 8'd1);
		// clear in the middle of a tile also restarts the counters
		send_item(OP_CLEAR, '0);
		send_pixel(8'd7, 8'd7, 8'd7, 8'd7);
		send_pixel(8'd1, 8'd2, 8'd3, 8'd4);
		send_read(16'd4);
		send_read(16'd9);
		drain();

		for (int p = 0; p < PHASES; p++)
			run_phase(p);

		repeat (20) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("** clipped_alpha_over_blit_unit: PASSED **");
		else
			$display("** clipped_alpha_over_blit_unit: FAILED **");
		$finish;
	end

	initial begin
		#20000000;
		$display("** clipped_alpha_over_blit_unit: FAILED **");
		$finish;
	end

endmodule
